// ===== design/bdr_pkg.sv =====
// shared constants, codes and helpers for the bounded deque ring
package bdr_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // one strobe per command, already qualified by the full/empty checks
    typedef struct packed {
        logic put_front;
        logic put_back;
        logic take_front;
        logic take_back;
    } t_cell_ctl;

    // sign-extend a stored word and keep the low 32 bits
    function automatic logic [31:0] widen(t_word d);
        logic signed [DATA_WIDTH-1:0] s;
        logic [63:0]                  w;
        s = d;
        w = 64'(s);
        return w[31:0];
    endfunction

endpackage

// ===== design/bdr_cell.sv =====
// one storage cell of the deque chain: a word and its valid bit
module bdr_cell
    import bdr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_word     i_word,
    input  t_word     i_left_data,
    input  logic      i_left_valid,
    input  t_word     i_right_data,
    input  logic      i_right_valid,
    output t_word     o_data,
    output logic      o_valid,
    output t_word     o_nxt_data,
    output logic      o_nxt_valid
);

    t_word r_data;
    logic  r_valid;
    t_word n_data;
    logic  n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.put_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctl.take_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctl.put_back) begin
            // first free cell takes the word
            if (!r_valid && i_left_valid) begin
                n_data  = i_word;
                n_valid = 1'b1;
            end
        end else if (i_ctl.take_back) begin
            // last occupied cell lets go
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    assign o_nxt_data  = n_data;
    assign o_nxt_valid = n_valid;

endmodule

// ===== design/bdr_tail_pick.sv =====
// selects the word of the last occupied cell in the chain
module bdr_tail_pick
    import bdr_pkg::*;
(
    input  logic [DEPTH-1:0] i_valid,
    input  t_word            i_data [DEPTH],
    output t_word            o_data
);

    logic [DEPTH:0]   w_valid_ext;
    logic [DEPTH-1:0] w_last;

    assign w_valid_ext = {1'b0, i_valid};

    always_comb begin
        o_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_last[i] = w_valid_ext[i] & ~w_valid_ext[i+1];
            o_data    = o_data | (i_data[i] & {DATA_WIDTH{w_last[i]}});
        end
    end

endmodule

// ===== design/bounded_deque_ring_core.sv =====
// top level: deque held in a chain of cells with a registered result stage
// the result is registered and appears in the cycle after its item is taken
// throughput: one item per cycle while the result stage is not held; every cell
//   updates from its neighbours in the same cycle, so that update sets the rate
// reset (synchronous, active low): cell valid bits, fill count and result
//   valid are cleared; cell words are not cleared and are never read unwritten
module bounded_deque_ring_core
    import bdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_popped_value,
    output logic [31:0] o_front_value,
    output logic [31:0] o_back_value,
    output logic        o_is_empty,
    output logic [4:0]  o_fill_count
);

    // input handshake: take an item whenever the result stage is free or draining
    logic w_accept;
    assign o_in_stall = o_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    // incoming word, cut to the stored width
    logic signed [31:0] w_value_s;
    logic [63:0]        w_value64;
    t_word              w_word;
    assign w_value_s = i_value;
    assign w_value64 = 64'(w_value_s);
    assign w_word    = w_value64[DATA_WIDTH-1:0];

    // fill count and full/empty checks
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_full;
    logic             w_empty;
    logic             w_is_push;
    logic [1:0]       w_status;
    t_cell_ctl        w_ctl;

    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_is_push = (i_command == CMD_PUSH_FRONT) || (i_command == CMD_PUSH_BACK);

    always_comb begin
        w_ctl    = '0;
        w_status = ST_OK;
        n_count  = r_count;
        if (w_is_push) begin
            if (w_full) begin
                w_status = ST_OVERFLOW;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                w_status = ST_UNDERFLOW;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
        // only a good command moves the chain
        if (w_accept && (w_status == ST_OK)) begin
            case (i_command)
                CMD_PUSH_FRONT: w_ctl.put_front  = 1'b1;
                CMD_PUSH_BACK:  w_ctl.put_back   = 1'b1;
                CMD_POP_FRONT:  w_ctl.take_front = 1'b1;
                CMD_POP_BACK:   w_ctl.take_back  = 1'b1;
                default:        w_ctl            = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // chain of cells, front at cell 0; words shift one place on front push/pop
    t_word            w_data     [DEPTH];
    t_word            w_nxt_data [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_nxt_valid;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left_data;
        logic  w_left_valid;
        t_word w_right_data;
        logic  w_right_valid;

        if (g == 0) begin : g_first
            // a front push feeds the new word in here
            assign w_left_data  = w_word;
            assign w_left_valid = 1'b1;
        end else begin : g_mid_left
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_data  = w_word;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_right
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        bdr_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_word        (w_word),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_nxt_data    (w_nxt_data[g]),
            .o_nxt_valid   (w_nxt_valid[g])
        );
    end

    // back word before the step (for a back pop) and after it (for the result)
    t_word w_tail_now;
    t_word w_tail_nxt;

    bdr_tail_pick u_tail_now (
        .i_valid (w_valid),
        .i_data  (w_data),
        .o_data  (w_tail_now)
    );

    bdr_tail_pick u_tail_nxt (
        .i_valid (w_nxt_valid),
        .i_data  (w_nxt_data),
        .o_data  (w_tail_nxt)
    );

    // result fields
    logic [31:0] w_popped;
    logic        w_nxt_empty;

    always_comb begin
        w_popped = '0;
        if (w_status == ST_OK) begin
            if (i_command == CMD_POP_FRONT) begin
                w_popped = widen(w_data[0]);
            end else if (i_command == CMD_POP_BACK) begin
                w_popped = widen(w_tail_now);
            end
        end
    end

    assign w_nxt_empty = (n_count == '0);

    // result register, loaded on every accepted item
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_popped;
    logic [31:0] r_front;
    logic [31:0] r_back;
    logic        r_empty;
    logic [4:0]  r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_accept | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_popped <= w_popped;
            r_front  <= w_nxt_empty ? '1 : widen(w_nxt_data[0]);
            r_back   <= w_nxt_empty ? '1 : widen(w_tail_nxt);
            r_empty  <= w_nxt_empty;
            r_fill   <= 5'(n_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_front_value  = r_front;
    assign o_back_value   = r_back;
    assign o_is_empty     = r_empty;
    assign o_fill_count   = r_fill;

    // checks
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("fill count disagrees with occupied cells");

    a_cells_packed_at_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("occupied cells are not contiguous from the front");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_fill_count == 5'd0)))
        else $error("empty flag disagrees with fill count");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_fill_count)))
        else $error("held item changed");

endmodule
